// File: rtl/cmvg_pkg.sv
// Shared types, constants and helper functions of the capsule mesh vertex generator.
package cmvg_pkg;

  // Fixed-point configuration.
  localparam int PHASE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 8;

  // The arctangent table has 24 entries, so at most 24 rotation cells.
  localparam int N_CELLS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int SH_W    = 5;
  localparam int TRIG_W  = 20;
  localparam int Z_W     = PHASE_BITS;

  // Shared multiplier and position arithmetic.
  localparam int MB_W    = 19;
  localparam int PROD_W  = TRIG_W + MB_W;
  localparam int PLO_W   = 17;
  localparam int CAP_W   = PROD_W + PLO_W + 1;
  localparam int POS_W   = 34;
  localparam int FSH     = 16 - FRAC_BITS;

  // Step divider.
  localparam int DIV_NUM_W = (PHASE_BITS + 1 > 24) ? PHASE_BITS + 1 : 24;
  localparam int DEN_W     = 9;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Latched geometry widths.
  localparam int H_W       = 24;
  localparam int H_ACC_W   = 25;
  localparam int U_ACC_W   = 18;

  localparam logic [PHASE_BITS-1:0] PHASE_QTR = PHASE_BITS'(1) << (PHASE_BITS - 2);
  localparam logic [DIV_NUM_W-1:0]  THETA_NUM0 = DIV_NUM_W'(1) << PHASE_BITS;
  localparam logic [DIV_NUM_W-1:0]  RHO_NUM0   = DIV_NUM_W'(1) << (PHASE_BITS - 1);
  localparam logic [DIV_NUM_W-1:0]  UV_NUM0    = DIV_NUM_W'(65536);

  localparam logic signed [TRIG_W-1:0] CORDIC_START = TRIG_W'(39797);
  localparam logic signed [PROD_W-1:0] HALF_LSB8    = PROD_W'(128);
  localparam logic signed [CAP_W-1:0]  CAP_RND      = CAP_W'(1) << 23;
  localparam logic signed [POS_W-1:0]  RND_F        = POS_W'((1 << FSH) >> 1);
  localparam logic signed [POS_W-1:0]  POS_MAX      = POS_W'(131071);
  localparam logic signed [POS_W-1:0]  POS_MIN      = POS_W'(-131072);

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [Z_W-1:0]    zang_t;

  // Data handed from one rotation cell to the next.
  typedef struct packed {
    logic       tag;
    logic [1:0] quad;
    trig_t      x;
    trig_t      y;
    zang_t      z;
  } cord_t;

  typedef enum logic [1:0] {
    REG_RADIUS      = 2'd0,
    REG_CYL_HEIGHT  = 2'd1,
    REG_STACK_REQ   = 2'd2,
    REG_SLICE_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEC_TOP  = 2'd0,
    SEC_SIDE = 2'd1,
    SEC_BOT  = 2'd2
  } section_t;

  typedef enum logic [2:0] {
    DV_THETA  = 3'd0,
    DV_RHO    = 3'd1,
    DV_HEIGHT = 3'd2,
    DV_U      = 3'd3,
    DV_V      = 3'd4
  } div_sel_t;

  // Arctangent of 2^-i as a fraction of a full turn, 32 bits.
  function automatic logic [31:0] atan_turn(input int i);
    case (i)
      0:  return 32'd536870912;
      1:  return 32'd316933406;
      2:  return 32'd167458907;
      3:  return 32'd85004756;
      4:  return 32'd42667331;
      5:  return 32'd21354465;
      6:  return 32'd10679838;
      7:  return 32'd5340245;
      8:  return 32'd2670163;
      9:  return 32'd1335087;
      10: return 32'd667544;
      11: return 32'd333772;
      12: return 32'd166886;
      13: return 32'd83443;
      14: return 32'd41722;
      15: return 32'd20861;
      16: return 32'd10430;
      17: return 32'd5215;
      18: return 32'd2608;
      19: return 32'd1304;
      20: return 32'd652;
      21: return 32'd326;
      22: return 32'd163;
      23: return 32'd81;
      default: return 32'd0;
    endcase
  endfunction

  // Rounded rotation angle of one cell in phase units.
  function automatic zang_t atan_phase(input int i);
    logic [32:0] t;
    t = {1'b0, atan_turn(i)} + (33'd1 << (31 - PHASE_BITS));
    return zang_t'(t >> (32 - PHASE_BITS));
  endfunction

endpackage

// File: rtl/cmvg_cordic_cell.sv
// One rotation cell of the CORDIC chain.
module cmvg_cordic_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         vld_in,
  input  cmvg_pkg::cord_t              d_in,
  input  logic [cmvg_pkg::SH_W-1:0]    shamt,
  input  cmvg_pkg::zang_t              angle,
  output logic                         vld_out,
  output cmvg_pkg::cord_t              d_out
);
  import cmvg_pkg::*;

  trig_t xs;
  trig_t ys;
  cord_t d_nxt;
  logic  vld_r;
  cord_t d_r;

  // Rotate toward zero residual angle.
  always_comb begin
    xs    = d_in.x >>> shamt;
    ys    = d_in.y >>> shamt;
    d_nxt = d_in;
    if (d_in.z >= 0) begin
      d_nxt.x = d_in.x - ys;
      d_nxt.y = d_in.y + xs;
      d_nxt.z = d_in.z - angle;
    end else begin
      d_nxt.x = d_in.x + ys;
      d_nxt.y = d_in.y - xs;
      d_nxt.z = d_in.z + angle;
    end
  end

  // Hand the result to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule

// File: rtl/cmvg_cordic_chain.sv
// Row of CORDIC cells producing cosine and sine components for one phase per cycle.
module cmvg_cordic_chain (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             tag,
  input  logic [cmvg_pkg::PHASE_BITS-1:0]  phase,
  output logic                             res_valid,
  output cmvg_pkg::cord_t                  res
);
  import cmvg_pkg::*;

  logic  [N_CELLS:0] vld;
  cord_t             stage [N_CELLS+1];

  // Start vector on the first quadrant; the quadrant rides along.
  always_comb begin
    vld[0]         = start;
    stage[0].tag   = tag;
    stage[0].quad  = phase[PHASE_BITS-1:PHASE_BITS-2];
    stage[0].x     = CORDIC_START;
    stage[0].y     = '0;
    stage[0].z     = zang_t'({2'b00, phase[PHASE_BITS-3:0]});
  end

  // One cell per rotation step.
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    cmvg_cordic_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_in  (vld[i]),
      .d_in    (stage[i]),
      .shamt   (SH_W'(i)),
      .angle   (atan_phase(i)),
      .vld_out (vld[i+1]),
      .d_out   (stage[i+1])
    );
  end

  assign res_valid = vld[N_CELLS];
  assign res       = stage[N_CELLS];

endmodule

// File: rtl/cmvg_divider.sv
// Restoring divider, one quotient bit per cycle, for the per-capsule step sizes.
module cmvg_divider (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [cmvg_pkg::DIV_NUM_W-1:0]  num,
  input  logic [cmvg_pkg::DEN_W-1:0]      den,
  output logic                            done,
  output logic [cmvg_pkg::DIV_NUM_W-1:0]  quo
);
  import cmvg_pkg::*;

  logic [DIV_NUM_W-1:0] nq_r;
  logic [DIV_NUM_W-1:0] nq_nxt;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     rem_nxt;
  logic [DEN_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       diff;
  logic                 ge;

  // Trial subtract of the divisor from the shifted remainder.
  always_comb begin
    trial   = {rem_r, nq_r[DIV_NUM_W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    nq_nxt  = {nq_r[DIV_NUM_W-2:0], ge};
  end

  // Iterate over all numerator bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        nq_r   <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        nq_r  <= nq_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = nq_r;

endmodule

// File: rtl/capsule_mesh_vertex_generator.sv
// Top level of the capsule mesh vertex generator.
//
// Each transfer on the in_ channel asks for one vertex; in_restart set starts a
// new capsule from vertex zero using the registers as they stand. Every input
// transfer yields exactly one transfer on the out_ channel. After the last
// vertex, and before the first restart, the result carries out_valid_res low
// and all other fields zero.
// Registers are written over the cfg_ channel (always ready); the user must write
// them only while the block is idle, which the block does not enforce. They take
// effect at the next restart. A plain vertex: two phases enter the CORDIC cell
// row, then seven products go through the one shared multiplier, then the
// positions are rounded and saturated. A restart adds five step divisions
// on the bit-serial divider. Items are worked one at a time: no new input is
// taken until the block is back in idle. One input is taken while a finished
// result still waits in the output register; a stalled receiver holds that
// result and stops the block only when the next result is ready. Reset empties
// the output, loads the register defaults and leaves the generator finished
// until a restart.
module capsule_mesh_vertex_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_res,
  output logic [17:0] out_pos_x,
  output logic [17:0] out_pos_y,
  output logic [17:0] out_pos_z,
  output logic [16:0] out_tex_u,
  output logic [16:0] out_tex_v,
  output logic [16:0] out_vertex_index,
  output logic        out_has_quad,
  output logic [16:0] out_quad_base,
  output logic [16:0] out_quad_top,
  output logic        out_last_vertex,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cmvg_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_TRIG = 7'b0000100,
    S_WAIT = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_POS  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Configuration registers.
  logic [15:0] radius_r;
  logic [15:0] cyl_height_r;
  logic [7:0]  stack_req_r;
  logic [7:0]  slice_cnt_r;

  // Values latched at restart.
  logic [15:0]           lat_radius_r;
  logic [15:0]           lat_height_r;
  logic [7:0]            lat_stacks_r;
  logic [7:0]            lat_slices_r;
  logic [PHASE_BITS-1:0] theta_step_r;
  logic [PHASE_BITS-1:0] rho_step_r;
  logic [H_W-1:0]        height_step_r;
  logic [16:0]           u_step_r;
  logic [16:0]           v_step_r;

  // Walk through the mesh.
  logic [1:0]            section_r;
  logic [7:0]            ring_r;
  logic [7:0]            slice_r;
  logic [16:0]           vcnt_r;
  logic [16:0]           tex_v_r;
  logic                  finished_r;
  logic [PHASE_BITS-1:0] slice_ph_r;
  logic [PHASE_BITS-1:0] ring_ph_r;
  logic [U_ACC_W-1:0]    u_acc_r;
  logic [H_ACC_W-1:0]    h_acc_r;
  logic                  emit_zero_r;

  // Step divider control.
  div_sel_t             div_sel_r;
  logic                 div_wait_r;
  logic                 div_start;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DEN_W-1:0]     div_den;
  logic [DIV_NUM_W-1:0] div_quo;

  // Trig and multiply datapath.
  logic                  trig_k_r;
  logic                  chain_start;
  logic                  chain_tag;
  logic [PHASE_BITS-1:0] chain_phase;
  logic                  chain_vld;
  cord_t                 chain_res;
  trig_t                 cos_v;
  trig_t                 sin_v;
  trig_t                 ct_r;
  trig_t                 st_r;
  trig_t                 cr_r;
  trig_t                 sr_r;
  logic [2:0]            mk_r;
  trig_t                 mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] ps_r;
  logic signed [PROD_W-1:0] pc_r;
  logic signed [PROD_W-1:0] pr_r;
  logic signed [PROD_W-1:0] xlo_r;
  logic signed [PROD_W-1:0] xhi_r;
  logic signed [PROD_W-1:0] zlo_r;
  logic signed [PROD_W-1:0] zhi_r;
  logic signed [CAP_W-1:0]  capx;
  logic signed [CAP_W-1:0]  capz;
  logic signed [POS_W-1:0]  half16;
  logic signed [POS_W-1:0]  hacc_s;
  logic signed [POS_W-1:0]  x16_nxt;
  logic signed [POS_W-1:0]  y16_nxt;
  logic signed [POS_W-1:0]  z16_nxt;
  logic signed [POS_W-1:0]  x16_r;
  logic signed [POS_W-1:0]  y16_r;
  logic signed [POS_W-1:0]  z16_r;

  // Vertex bookkeeping.
  logic [PHASE_BITS-1:0] slice_tp;
  logic [PHASE_BITS-1:0] ring_tp;
  logic [7:0]            limit;
  logic                  slice_wrap;
  logic                  ring_wrap;
  logic                  quad;
  logic                  last;
  logic [16:0]           u_val;
  logic                  out_free;
  logic                  in_xfer;

  // Output register.
  logic        out_valid_r;
  logic        o_valid_res_r;
  logic [17:0] o_pos_x_r;
  logic [17:0] o_pos_y_r;
  logic [17:0] o_pos_z_r;
  logic [16:0] o_tex_u_r;
  logic [16:0] o_tex_v_r;
  logic [16:0] o_vidx_r;
  logic        o_has_quad_r;
  logic [16:0] o_quad_base_r;
  logic [16:0] o_quad_top_r;
  logic        o_last_r;

  // Round a Q.16 position to the output fraction and saturate to 18 bits.
  function automatic logic [17:0] pos_sat(input logic signed [POS_W-1:0] v16);
    logic signed [POS_W-1:0] v;
    v = (v16 + RND_F) >>> FSH;
    if (v > POS_MAX) begin
      v = POS_MAX;
    end else if (v < POS_MIN) begin
      v = POS_MIN;
    end
    return v[17:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Step divider operand selection.
  always_comb begin
    case (div_sel_r)
      DV_THETA: begin
        div_num = THETA_NUM0 + DIV_NUM_W'(lat_slices_r >> 1);
        div_den = DEN_W'(lat_slices_r);
      end
      DV_RHO: begin
        div_num = RHO_NUM0 + DIV_NUM_W'(lat_stacks_r >> 1);
        div_den = DEN_W'(lat_stacks_r);
      end
      DV_HEIGHT: begin
        div_num = DIV_NUM_W'({lat_height_r, 8'h00}) + DIV_NUM_W'(lat_stacks_r >> 1);
        div_den = DEN_W'(lat_stacks_r);
      end
      DV_U: begin
        div_num = UV_NUM0 + DIV_NUM_W'(lat_slices_r >> 1);
        div_den = DEN_W'(lat_slices_r);
      end
      default: begin
        div_num = UV_NUM0 + DIV_NUM_W'(lat_stacks_r);
        div_den = {lat_stacks_r, 1'b0};
      end
    endcase
  end

  assign div_start = (state_r == S_DIV) && !div_wait_r;

  cmvg_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Phases for the slice angle and the ring angle.
  assign slice_tp = (slice_r == lat_slices_r) ? '0 : slice_ph_r;
  assign ring_tp  = ring_ph_r + ((section_r == SEC_BOT) ? PHASE_QTR : '0);

  assign chain_start = (state_r == S_TRIG);
  assign chain_tag   = trig_k_r;
  assign chain_phase = trig_k_r ? ring_tp : slice_tp;

  cmvg_cordic_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (chain_start),
    .tag       (chain_tag),
    .phase     (chain_phase),
    .res_valid (chain_vld),
    .res       (chain_res)
  );

  // Map the first-quadrant result back to the full turn.
  always_comb begin
    case (chain_res.quad)
      2'd0: begin
        cos_v = chain_res.x;
        sin_v = chain_res.y;
      end
      2'd1: begin
        cos_v = -chain_res.y;
        sin_v = chain_res.x;
      end
      2'd2: begin
        cos_v = -chain_res.x;
        sin_v = -chain_res.y;
      end
      default: begin
        cos_v = chain_res.y;
        sin_v = -chain_res.x;
      end
    endcase
  end

  // Shared multiplier operands: radius products, then the split second products.
  always_comb begin
    case (mk_r)
      3'd0: begin
        mul_a = st_r;
        mul_b = MB_W'(lat_radius_r);
      end
      3'd1: begin
        mul_a = ct_r;
        mul_b = MB_W'(lat_radius_r);
      end
      3'd2: begin
        mul_a = cr_r;
        mul_b = MB_W'(lat_radius_r);
      end
      3'd3: begin
        mul_a = sr_r;
        mul_b = MB_W'(ps_r[PLO_W-1:0]);
      end
      3'd4: begin
        mul_a = sr_r;
        mul_b = MB_W'(ps_r >>> PLO_W);
      end
      3'd5: begin
        mul_a = sr_r;
        mul_b = MB_W'(pc_r[PLO_W-1:0]);
      end
      3'd6: begin
        mul_a = sr_r;
        mul_b = MB_W'(pc_r >>> PLO_W);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Positions in Q.16 for the side and for the caps.
  always_comb begin
    half16 = POS_W'({lat_height_r, 7'h00});
    hacc_s = POS_W'(h_acc_r);
    capx   = (CAP_W'(xhi_r) <<< PLO_W) + CAP_W'(xlo_r) + CAP_RND;
    capz   = (CAP_W'(zhi_r) <<< PLO_W) + CAP_W'(zlo_r) + CAP_RND;
    if (section_r == SEC_SIDE) begin
      x16_nxt = POS_W'((ps_r + HALF_LSB8) >>> 8);
      z16_nxt = POS_W'((pc_r + HALF_LSB8) >>> 8);
      y16_nxt = half16 - hacc_s;
    end else begin
      x16_nxt = POS_W'(capx >>> 24);
      z16_nxt = POS_W'(capz >>> 24);
      y16_nxt = POS_W'((pr_r + HALF_LSB8) >>> 8);
      if (section_r == SEC_BOT) begin
        y16_nxt = y16_nxt - half16;
      end else begin
        y16_nxt = y16_nxt + half16;
      end
    end
  end

  // Quad, last vertex and texture u of the current vertex.
  always_comb begin
    limit      = (section_r == SEC_SIDE) ? lat_stacks_r : (lat_stacks_r >> 1);
    slice_wrap = (slice_r == lat_slices_r);
    ring_wrap  = (ring_r == limit);
    quad       = (ring_r < limit) && (slice_r < lat_slices_r);
    last       = (section_r == SEC_BOT) && ring_wrap && slice_wrap;
    if (u_acc_r > U_ACC_W'(65536)) begin
      u_val = '0;
    end else begin
      u_val = 17'(U_ACC_W'(65536) - u_acc_r);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_restart) begin
            state_nxt = S_DIV;
          end else if (finished_r) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_TRIG;
          end
        end
      end
      S_DIV: begin
        if (div_done && (div_sel_r == DV_V)) begin
          state_nxt = S_TRIG;
        end
      end
      S_TRIG: begin
        if (trig_k_r) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (chain_vld && chain_res.tag) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mk_r == 3'd7) begin
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      radius_r     <= 16'd256;
      cyl_height_r <= 16'd256;
      stack_req_r  <= 8'd2;
      slice_cnt_r  <= 8'd16;
      section_r    <= SEC_TOP;
      ring_r       <= '0;
      slice_r      <= '0;
      vcnt_r       <= '0;
      tex_v_r      <= '0;
      finished_r   <= 1'b1;
      slice_ph_r   <= '0;
      ring_ph_r    <= '0;
      u_acc_r      <= '0;
      h_acc_r      <= '0;
      emit_zero_r  <= 1'b0;
      div_sel_r    <= DV_THETA;
      div_wait_r   <= 1'b0;
      trig_k_r     <= 1'b0;
      mk_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prod_r  <= mul_a * mul_b;

      // Register writes.
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_RADIUS:      radius_r     <= cfg_data;
          REG_CYL_HEIGHT:  cyl_height_r <= cfg_data;
          REG_STACK_REQ:   stack_req_r  <= cfg_data[7:0];
          REG_SLICE_COUNT: slice_cnt_r  <= cfg_data[7:0];
          default: ;
        endcase
      end

      // The receiver took the waiting result.
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          emit_zero_r <= 1'b0;
          trig_k_r    <= 1'b0;
          mk_r        <= '0;
          if (in_xfer) begin
            emit_zero_r <= !in_restart && finished_r;
            if (in_restart) begin
              lat_radius_r <= radius_r;
              lat_height_r <= cyl_height_r;
              lat_stacks_r <= (stack_req_r > 8'd1) ? {stack_req_r[7:1], 1'b0} : 8'd2;
              lat_slices_r <= (slice_cnt_r == 8'd0) ? 8'd1 : slice_cnt_r;
              section_r    <= SEC_TOP;
              ring_r       <= '0;
              slice_r      <= '0;
              vcnt_r       <= '0;
              tex_v_r      <= '0;
              slice_ph_r   <= '0;
              ring_ph_r    <= '0;
              u_acc_r      <= '0;
              h_acc_r      <= '0;
              finished_r   <= 1'b0;
              div_sel_r    <= DV_THETA;
              div_wait_r   <= 1'b0;
            end
          end
        end
        S_DIV: begin
          if (div_start) begin
            div_wait_r <= 1'b1;
          end
          if (div_done) begin
            div_wait_r <= 1'b0;
            case (div_sel_r)
              DV_THETA:  theta_step_r  <= div_quo[PHASE_BITS-1:0];
              DV_RHO:    rho_step_r    <= div_quo[PHASE_BITS-1:0];
              DV_HEIGHT: height_step_r <= div_quo[H_W-1:0];
              DV_U:      u_step_r      <= div_quo[16:0];
              default:   v_step_r      <= div_quo[16:0];
            endcase
            if (div_sel_r != DV_V) begin
              div_sel_r <= div_sel_t'(div_sel_r + 3'd1);
            end
          end
        end
        S_TRIG: begin
          trig_k_r <= !trig_k_r;
        end
        S_WAIT: begin
          if (chain_vld) begin
            if (!chain_res.tag) begin
              ct_r <= cos_v;
              st_r <= sin_v;
            end else begin
              cr_r <= cos_v;
              sr_r <= sin_v;
            end
          end
        end
        S_MUL: begin
          mk_r <= mk_r + 3'd1;
          case (mk_r)
            3'd1: ps_r  <= prod_r;
            3'd2: pc_r  <= prod_r;
            3'd3: pr_r  <= prod_r;
            3'd4: xlo_r <= prod_r;
            3'd5: xhi_r <= prod_r;
            3'd6: zlo_r <= prod_r;
            3'd7: zhi_r <= prod_r;
            default: ;
          endcase
        end
        S_POS: begin
          x16_r <= x16_nxt;
          y16_r <= y16_nxt;
          z16_r <= z16_nxt;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (emit_zero_r) begin
              o_valid_res_r <= 1'b0;
              o_pos_x_r     <= '0;
              o_pos_y_r     <= '0;
              o_pos_z_r     <= '0;
              o_tex_u_r     <= '0;
              o_tex_v_r     <= '0;
              o_vidx_r      <= '0;
              o_has_quad_r  <= 1'b0;
              o_quad_base_r <= '0;
              o_quad_top_r  <= '0;
              o_last_r      <= 1'b0;
            end else begin
              o_valid_res_r <= 1'b1;
              o_pos_x_r     <= pos_sat(x16_r);
              o_pos_y_r     <= pos_sat(y16_r);
              o_pos_z_r     <= pos_sat(z16_r);
              o_tex_u_r     <= u_val;
              o_tex_v_r     <= tex_v_r;
              o_vidx_r      <= vcnt_r;
              o_has_quad_r  <= quad;
              o_quad_base_r <= quad ? vcnt_r : '0;
              o_quad_top_r  <= quad ? (vcnt_r + 17'(lat_slices_r) + 17'd2) : '0;
              o_last_r      <= last;

              // Advance to the next vertex.
              vcnt_r <= vcnt_r + 17'd1;
              if (!slice_wrap) begin
                slice_r    <= slice_r + 8'd1;
                slice_ph_r <= slice_ph_r + theta_step_r;
                u_acc_r    <= u_acc_r + U_ACC_W'(u_step_r);
              end else begin
                slice_r    <= '0;
                slice_ph_r <= '0;
                u_acc_r    <= '0;
                tex_v_r    <= tex_v_r + v_step_r;
                if (!ring_wrap) begin
                  ring_r    <= ring_r + 8'd1;
                  ring_ph_r <= ring_ph_r + rho_step_r;
                  h_acc_r   <= h_acc_r + H_ACC_W'(height_step_r);
                end else begin
                  ring_r    <= '0;
                  ring_ph_r <= '0;
                  h_acc_r   <= '0;
                  section_r <= section_r + 2'd1;
                end
              end
              if (last) begin
                finished_r <= 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_valid_res    = o_valid_res_r;
  assign out_pos_x        = o_pos_x_r;
  assign out_pos_y        = o_pos_y_r;
  assign out_pos_z        = o_pos_z_r;
  assign out_tex_u        = o_tex_u_r;
  assign out_tex_v        = o_tex_v_r;
  assign out_vertex_index = o_vidx_r;
  assign out_has_quad     = o_has_quad_r;
  assign out_quad_base    = o_quad_base_r;
  assign out_quad_top     = o_quad_top_r;
  assign out_last_vertex  = o_last_r;

`ifndef SYNTHESIS
  // A restart transfer always goes through the step divisions.
  a_restart_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_restart) |=> (state_r == S_DIV))
    else $error("restart did not start the step divisions");

  // The last vertex is a real vertex.
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_vertex) |-> out_valid_res)
    else $error("last vertex flagged on an idle result");

  // Quad indices are zero without a quad.
  a_no_quad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_quad) |-> (out_quad_base == 17'd0 && out_quad_top == 17'd0))
    else $error("quad indices set without a quad");

  // A quad starts at the vertex that carries it.
  a_quad_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_quad) |-> (out_quad_base == out_vertex_index))
    else $error("quad base differs from vertex index");

  // The ring phase leaves the cell row right behind the slice phase.
  a_chain_order: assert property (@(posedge clk) disable iff (!rst_n)
    (chain_vld && chain_res.tag) |-> ($past(chain_vld) && !$past(chain_res.tag)))
    else $error("ring phase result out of order");
`endif

endmodule
